@@ sv/aro_pkg.sv @@
// Shared types, constants and tables for the axis rotation offset block.
`default_nettype none

package aro_pkg;

  // Default configuration
  localparam int CordicStagesDef = 16;
  localparam int FracBitsDef     = 16;

  // Coordinate and stream widths
  localparam int CoordW     = 32;
  localparam int AngleW     = 16;
  localparam int ModeW      = 2;
  localparam int InTdataW   = 184;
  localparam int OutTdataW  = 96;
  localparam int TurnW      = 32;

  // Axis select codes
  typedef enum logic [ModeW-1:0] {
    ModeX = 2'd0,
    ModeY = 2'd1,
    ModeZ = 2'd2
  } aro_mode_e;

  // Payload that rides along the CORDIC chain
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [CoordW-1:0] coord_a;
    logic signed [CoordW-1:0] coord_b;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     flip;
  } aro_item_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [TurnW-1:0] atan_turn(input int idx);
    logic [TurnW-1:0] r;
    unique case (idx)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051E;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2F;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2F9;
      15: r = 32'h0000_517D;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A30;
      19: r = 32'h0000_0518;
      20: r = 32'h0000_028C;
      21: r = 32'h0000_0146;
      22: r = 32'h0000_00A3;
      23: r = 32'h0000_0051;
      24: r = 32'h0000_0029;
      25: r = 32'h0000_0014;
      26: r = 32'h0000_000A;
      27: r = 32'h0000_0005;
      28: r = 32'h0000_0003;
      29: r = 32'h0000_0001;
      30: r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // Start value of x: CORDIC inverse gain, rounded to frac_bits fraction bits
  function automatic longint cordic_x_init(input int frac_bits);
    longint inv_gain;
    inv_gain = 64'd2608131496;
    return (inv_gain + (longint'(1) << (31 - frac_bits))) >>> (32 - frac_bits);
  endfunction

endpackage

`default_nettype wire

@@ sv/aro_cordic_cell.sv @@
// One CORDIC rotation cell: a single micro-rotation plus the payload it carries.
`default_nettype none

module aro_cordic_cell #(
  parameter int Stage = 0,
  parameter int W     = 18
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire aro_pkg::aro_item_t               item_i,
  input  wire logic signed [W-1:0]              x_i,
  input  wire logic signed [W-1:0]              y_i,
  input  wire logic signed [aro_pkg::TurnW-1:0] z_i,
  output logic                                  valid_o,
  output aro_pkg::aro_item_t                    item_o,
  output logic signed [W-1:0]                   x_o,
  output logic signed [W-1:0]                   y_o,
  output logic signed [aro_pkg::TurnW-1:0]      z_o
);
  import aro_pkg::*;

  localparam logic signed [TurnW-1:0] Atan = atan_turn(Stage);

  logic                     valid_q;
  aro_item_t                item_q;
  logic signed [W-1:0]      x_q, x_d, y_q, y_d;
  logic signed [TurnW-1:0]  z_q, z_d;
  logic signed [W-1:0]      dx, dy;

  // Micro-rotation toward z = 0; shifts floor
  always_comb begin
    dx = y_i >>> Stage;
    dy = x_i >>> Stage;
    if (!z_i[TurnW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

`default_nettype wire

@@ sv/aro_combine.sv @@
// Rotated offset and position update: products, sums, rounding and saturation.
`default_nettype none

module aro_combine #(
  parameter int W        = 18,
  parameter int FracBits = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire aro_pkg::aro_item_t                item_i,
  input  wire logic signed [W-1:0]               cos_i,
  input  wire logic signed [W-1:0]               sin_i,
  output logic                                   valid_o,
  output logic signed [aro_pkg::CoordW-1:0]      out_x_o,
  output logic signed [aro_pkg::CoordW-1:0]      out_y_o,
  output logic signed [aro_pkg::CoordW-1:0]      out_z_o
);
  import aro_pkg::*;

  localparam int PW = CoordW + W;       // product
  localparam int SW = PW + 1;           // sum of two products
  localparam int RW = SW + 1 - FracBits; // rounded offset
  localparam int AW = RW + 1;           // position plus offset

  // Product stage
  logic                 prd_valid_q;
  aro_item_t            prd_item_q;
  logic signed [PW-1:0] ac_q, bs_q, as_q, bc_q;

  // Sum stage
  logic                 sum_valid_q;
  aro_item_t            sum_item_q;
  logic signed [SW-1:0] o1_q, o1_d, o2_q, o2_d;

  // Output stage
  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic signed [SW:0]       o1_ext, o2_ext;
  logic signed [RW-1:0]     o1_r, o2_r;
  logic signed [AW-1:0]     off_x, off_y, off_z;

  localparam logic signed [SW:0] Half = (SW+1)'(1) <<< (FracBits - 1);

  // Saturate a widened sum to the coordinate range
  function automatic logic signed [CoordW-1:0] sat_add(
    input logic signed [CoordW-1:0] pos,
    input logic signed [AW-1:0]     off
  );
    logic signed [AW-1:0] s;
    s = $signed({{(AW-CoordW){pos[CoordW-1]}}, pos}) + off;
    if (s > $signed(AW'({1'b0, {(CoordW-1){1'b1}}}))) begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end else if (s < $signed({{(AW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}})) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return s[CoordW-1:0];
    end
  endfunction

  // Sums; a half-turn fold negates cos and sin, so swap the signs here
  always_comb begin
    if (prd_item_q.flip) begin
      o1_d = ac_q - bs_q;
      o2_d = as_q + bc_q;
    end else begin
      o1_d = bs_q - ac_q;
      o2_d = -as_q - bc_q;
    end
  end

  // Round half up to Q16.16, then add to the selected components
  always_comb begin
    o1_ext = $signed({o1_q[SW-1], o1_q}) + Half;
    o2_ext = $signed({o2_q[SW-1], o2_q}) + Half;
    o1_r   = o1_ext[SW:FracBits];
    o2_r   = o2_ext[SW:FracBits];
    off_x  = '0;
    off_y  = '0;
    off_z  = '0;
    unique case (sum_item_q.mode)
      ModeX: begin
        off_x = $signed({o1_r[RW-1], o1_r});
        off_y = $signed({o2_r[RW-1], o2_r});
      end
      ModeY: begin
        off_y = $signed({o1_r[RW-1], o1_r});
        off_z = $signed({o2_r[RW-1], o2_r});
      end
      ModeZ: begin
        off_x = $signed({o1_r[RW-1], o1_r});
        off_z = $signed({o2_r[RW-1], o2_r});
      end
      default: begin
        // no axis: position passes through
      end
    endcase
    out_x_d = sat_add(sum_item_q.pos_x, off_x);
    out_y_d = sat_add(sum_item_q.pos_y, off_y);
    out_z_d = sat_add(sum_item_q.pos_z, off_z);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      prd_valid_q <= valid_i;
      sum_valid_q <= prd_valid_q;
      out_valid_q <= sum_valid_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prd_item_q <= item_i;
      ac_q       <= item_i.coord_a * cos_i;
      bs_q       <= item_i.coord_b * sin_i;
      as_q       <= item_i.coord_a * sin_i;
      bc_q       <= item_i.coord_b * cos_i;
      sum_item_q <= prd_item_q;
      o1_q       <= o1_d;
      o2_q       <= o2_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_z_q    <= out_z_d;
    end
  end

  assign valid_o = out_valid_q;
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

`default_nettype wire

@@ sv/axis_rotation_offset.sv @@
// Top level: rotates a point by a binary angle and adds it to a 3D position.
//
// Input stream (s_axis): one item per handshake carrying mode, angle,
// point (coord_a, coord_b) and position (pos_x, pos_y, pos_z), Q16.16.
// Output stream (m_axis): one item per input, out_x/out_y/out_z, Q16.16,
// saturated. Items leave in the order they arrive.
// Registers: each CORDIC cell, then the product, sum and round/saturate stages.
// Throughput: one item per cycle unless the output stalls; the unrolled
// chain of CORDIC cells takes a new item every clock while earlier ones
// are in flight.
// Stall: when the output item is not taken, the whole pipeline holds and
// s_axis_tready drops; it is high whenever the output register is empty
// or being drained in the same cycle.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
`default_nettype none

module axis_rotation_offset #(
  parameter int CORDIC_STAGES = aro_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = aro_pkg::FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // mode[1:0], angle[17:2], coord_a[49:18], coord_b[81:50],
  // pos_x[113:82], pos_y[145:114], pos_z[177:146], zero pad[183:178]
  input  wire logic [aro_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [aro_pkg::OutTdataW-1:0]      m_axis_tdata
);
  import aro_pkg::*;

  localparam int W = FRAC_BITS + 2;
  localparam logic signed [W-1:0] XInit = W'(cordic_x_init(FRAC_BITS));

  logic en;

  logic                    cell_valid [CORDIC_STAGES+1];
  aro_item_t               cell_item  [CORDIC_STAGES+1];
  logic signed [W-1:0]     cell_x     [CORDIC_STAGES+1];
  logic signed [W-1:0]     cell_y     [CORDIC_STAGES+1];
  logic signed [TurnW-1:0] cell_z     [CORDIC_STAGES+1];

  logic [AngleW-1:0]        angle;
  logic signed [CoordW-1:0] out_x, out_y, out_z;
  logic                     out_valid;

  // Pipeline advances unless a finished item is stuck at the output
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack and fold the angle into [-quarter, quarter) turn
  always_comb begin
    angle                = s_axis_tdata[17:2];
    cell_valid[0]        = s_axis_tvalid;
    cell_item[0].mode    = s_axis_tdata[1:0];
    cell_item[0].coord_a = s_axis_tdata[49:18];
    cell_item[0].coord_b = s_axis_tdata[81:50];
    cell_item[0].pos_x   = s_axis_tdata[113:82];
    cell_item[0].pos_y   = s_axis_tdata[145:114];
    cell_item[0].pos_z   = s_axis_tdata[177:146];
    cell_item[0].flip    = angle[AngleW-1] ^ angle[AngleW-2];
    cell_x[0]            = XInit;
    cell_y[0]            = '0;
    cell_z[0]            = {angle[AngleW-1] ^ cell_item[0].flip, angle[AngleW-2:0],
                            {(TurnW-AngleW){1'b0}}};
  end

  // Chain of CORDIC cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    aro_cordic_cell #(
      .Stage (i),
      .W     (W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[i]),
      .item_i  (cell_item[i]),
      .x_i     (cell_x[i]),
      .y_i     (cell_y[i]),
      .z_i     (cell_z[i]),
      .valid_o (cell_valid[i+1]),
      .item_o  (cell_item[i+1]),
      .x_o     (cell_x[i+1]),
      .y_o     (cell_y[i+1]),
      .z_o     (cell_z[i+1])
    );
  end

  // Residual angle of the last cell is not needed
  logic unused_z;
  assign unused_z = ^cell_z[CORDIC_STAGES];

  // Offset, position update and output register
  aro_combine #(
    .W        (W),
    .FracBits (FRAC_BITS)
  ) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cell_valid[CORDIC_STAGES]),
    .item_i  (cell_item[CORDIC_STAGES]),
    .cos_i   (cell_x[CORDIC_STAGES]),
    .sin_i   (cell_y[CORDIC_STAGES]),
    .valid_o (out_valid),
    .out_x_o (out_x),
    .out_y_o (out_y),
    .out_z_o (out_z)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_z, out_y, out_x};

endmodule

`default_nettype wire

@@ sv/aro_checker.sv @@
// Port-level checks for the axis rotation offset block, bound to its top level.
`default_nettype none

module aro_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [aro_pkg::OutTdataW-1:0]   m_axis_tdata
);

  // Input side is ready exactly when the output register can move
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("s_axis_tready does not follow output occupancy");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled output item stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // A stalled output item keeps its data
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind axis_rotation_offset aro_checker u_aro_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/axis_rotation_offset_checker.sv @@
// Checker for the rotation offset block: predicts each output item and compares it.
`timescale 1ns / 1ps

module axis_rotation_offset_checker #(
  parameter int CORDIC_STAGES = aro_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = aro_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // mode, angle, coord_a, coord_b, pos_x, pos_y, pos_z, zero pad
  input  logic [aro_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_z
  input  logic [aro_pkg::OutTdataW-1:0] m_axis_tdata,
  output int                            errors_o,
  output int                            pending_o
);
  import aro_pkg::*;

  // Field offsets inside the input item
  localparam int AngleLo = ModeW;
  localparam int ALo     = AngleLo + AngleW;
  localparam int BLo     = ALo + CoordW;
  localparam int XLo     = BLo + CoordW;
  localparam int YLo     = XLo + CoordW;
  localparam int ZLo     = YLo + CoordW;

  localparam longint InvGainQ32 = 64'd2608131496;

  logic [OutTdataW-1:0] expected_pos_q[$];
  int                   fail_count = 0;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [TurnW-1:0] atan_step(input int idx);
    case (idx)
      0:  return 32'h2000_0000;
      1:  return 32'h12E4_051E;
      2:  return 32'h09FB_385B;
      3:  return 32'h0511_11D4;
      4:  return 32'h028B_0D43;
      5:  return 32'h0145_D7E1;
      6:  return 32'h00A2_F61E;
      7:  return 32'h0051_7C55;
      8:  return 32'h0028_BE53;
      9:  return 32'h0014_5F2F;
      10: return 32'h000A_2F98;
      11: return 32'h0005_17CC;
      12: return 32'h0002_8BE6;
      13: return 32'h0001_45F3;
      14: return 32'h0000_A2F9;
      15: return 32'h0000_517D;
      16: return 32'h0000_28BE;
      17: return 32'h0000_145F;
      18: return 32'h0000_0A30;
      19: return 32'h0000_0518;
      20: return 32'h0000_028C;
      21: return 32'h0000_0146;
      22: return 32'h0000_00A3;
      23: return 32'h0000_0051;
      24: return 32'h0000_0029;
      25: return 32'h0000_0014;
      26: return 32'h0000_000A;
      27: return 32'h0000_0005;
      28: return 32'h0000_0003;
      29: return 32'h0000_0001;
      30: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Product sum back to Q16.16, rounding half up
  function automatic longint round_to_q16(input longint v);
    return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [CoordW-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[CoordW-1:0];
  endfunction

  // Rotate (-a,-b) by the angle and add it to the selected position components
  function automatic logic [OutTdataW-1:0] offset_position(input logic [InTdataW-1:0] d);
    logic [ModeW-1:0]  mode;
    logic [AngleW-1:0] angle;
    logic [TurnW-1:0]  turn;
    logic              flip;
    longint            a, b, px, py, pz;
    longint            x, y, z, dx, dy, step, o1, o2;
    int                n;
    mode  = d[0 +: ModeW];
    angle = d[AngleLo +: AngleW];
    a     = longint'($signed(d[ALo +: CoordW]));
    b     = longint'($signed(d[BLo +: CoordW]));
    px    = longint'($signed(d[XLo +: CoordW]));
    py    = longint'($signed(d[YLo +: CoordW]));
    pz    = longint'($signed(d[ZLo +: CoordW]));

    // second and third quadrant fold by a half turn, negate afterwards
    turn = {angle, 16'h0000};
    flip = angle[15] ^ angle[14];
    if (flip) turn = turn - 32'h8000_0000;
    z = longint'($signed(turn));

    x = (InvGainQ32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    y = 0;
    n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = atan_step(i);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end

    o1 = round_to_q16(-a * x + b * y);
    o2 = round_to_q16(-a * y - b * x);

    case (mode)
      ModeX: begin
        px = px + o1;
        py = py + o2;
      end
      ModeY: begin
        py = py + o1;
        pz = pz + o2;
      end
      ModeZ: begin
        px = px + o1;
        pz = pz + o2;
      end
      default: ;  // no axis: position passes through
    endcase
    return {clamp32(pz), clamp32(py), clamp32(px)};
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // Output side first: an item accepted now cannot leave in the same cycle
  always @(posedge clk_i) begin : watch
    logic [OutTdataW-1:0] got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pos_q.size() == 0) begin
          report_mismatch($sformatf("output item with none pending: %h", got));
        end else begin
          want = expected_pos_q.pop_front();
          if (got[0 +: CoordW] !== want[0 +: CoordW])
            report_mismatch($sformatf("out_x got %h expected %h",
                                      got[0 +: CoordW], want[0 +: CoordW]));
          if (got[CoordW +: CoordW] !== want[CoordW +: CoordW])
            report_mismatch($sformatf("out_y got %h expected %h",
                                      got[CoordW +: CoordW], want[CoordW +: CoordW]));
          if (got[2*CoordW +: CoordW] !== want[2*CoordW +: CoordW])
            report_mismatch($sformatf("out_z got %h expected %h",
                                      got[2*CoordW +: CoordW], want[2*CoordW +: CoordW]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pos_q.push_back(offset_position(s_axis_tdata));
    end
    errors_o  <= fail_count;
    pending_o <= expected_pos_q.size();
  end

endmodule

@@ tb/axis_rotation_offset_tb.sv @@
// Testbench top for the rotation offset block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module axis_rotation_offset_tb;
  import aro_pkg::*;

  localparam int Latency      = CordicStagesDef + 3;
  localparam int CycleLimit   = 200000;
  localparam int RandomItems  = 450;
  localparam logic [ModeW-1:0]  ModeNone = 2'd3;  // no axis selected
  localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;
  localparam logic [CoordW-1:0] One      = 32'h0001_0000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  int errors;
  int pending;
  int cycles = 0;
  bit sender_calm = 1'b0;

  axis_rotation_offset u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  axis_rotation_offset_checker #(
    .CORDIC_STAGES (CordicStagesDef),
    .FRAC_BITS     (FracBitsDef)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stalls per item, with stall-free stretches
  initial begin : drain
    int  stall;
    bit  calm;
    calm = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One input item; tvalid stays high afterwards so the next call can follow at once
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [AngleW-1:0] angle,
                           input logic [CoordW-1:0] a, input logic [CoordW-1:0] b,
                           input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                           input logic [CoordW-1:0] pz);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({pz, py, px, b, a, angle, mode});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every predicted item has come out
  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mix of extremes, small values and full-range values
  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return CoordMax;
      1:       return CoordMin;
      2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [AngleW-1:0] pick_angle();
    // quadrant edges get extra weight, the fold sits there
    if ($urandom_range(0, 4) == 0)
      return AngleW'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
    return AngleW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ModeW-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 9) return ModeNone;
    return ModeW'(r % 3);
  endfunction

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quadrants, every mode, Y mode using (a,b), passthrough, saturation
    send_item(ModeX, 16'd0,     32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ModeX, 16'd0,     One, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ModeX, 16'd16384, One, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ModeX, 16'd32768, One, 2 * One, One, One, One);
    send_item(ModeX, 16'd49152, One, 2 * One, One, One, One);
    send_item(ModeY, 16'd8192,  One, 3 * One, 32'd0, 32'd0, 32'd0);
    send_item(ModeY, 16'd0,     32'd0, 5 * One, 7 * One, -7 * One, One);
    send_item(ModeZ, 16'd12000, -3 * One, One, 2 * One, 4 * One, -2 * One);
    send_item(ModeNone, 16'd12345, CoordMax, CoordMin, CoordMax, CoordMin, 32'h1234_5678);
    send_item(ModeNone, 16'd65535, 32'hDEAD_BEEF, One, 32'h8765_4321, CoordMax, CoordMin);
    send_item(ModeX, 16'd65535, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    send_item(ModeX, 16'd32768, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin);
    send_item(ModeY, 16'd16383, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
    send_item(ModeY, 16'd16385, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax);
    send_item(ModeZ, 16'd32767, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax);
    send_item(ModeZ, 16'd49151, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin);
    send_item(ModeZ, 16'd49153, One, -One, CoordMax, 32'd0, CoordMin);
    send_item(ModeX, 16'd1,     -One, -One, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_item(ModeY, 16'd24576, 32'h0000_8000, 32'hFFFF_8000, 32'd0, 32'd0, 32'd0);
    send_item(ModeZ, 16'd40960, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    wait_empty();

    // Random: occasional full drain along the way
    for (int k = 0; k < RandomItems; k++) begin
      send_item(pick_mode(), pick_angle(), pick_coord(), pick_coord(),
                pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(0, 99) == 0) wait_empty();
    end
    wait_empty();
    repeat (Latency + 10) @(posedge clk_i);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/aro_pkg.sv
sv/aro_cordic_cell.sv
sv/aro_combine.sv
sv/axis_rotation_offset.sv
sv/aro_checker.sv
tb/axis_rotation_offset_checker.sv
tb/axis_rotation_offset_tb.sv
